FILE: rtl/pti_pkg.sv
package pti_pkg;

    localparam int DEPTH     = 1024;
    localparam int AW        = $clog2(DEPTH);
    localparam int NW        = 11;
    localparam int XW        = 37;
    localparam int UW        = XW - 1;
    localparam int QW        = 33;
    localparam int UNIT_HOUR = 3600;
    localparam int UNIT_DAY  = 86400;
    localparam int DIV_STEPS = 32;
    localparam int MD_STEPS  = 33;
    localparam int UD_STEPS  = 3;

    // floor(2^32 / unit)
    localparam logic [31:0] RECIP_HOUR = 32'd1193046;
    localparam logic [31:0] RECIP_DAY  = 32'd49710;

    localparam int IN_TDATA_W = 112;
    localparam int OFS_INDEX  = 0;
    localparam int OFS_TIME   = 10;
    localparam int OFS_VALUE  = 42;
    localparam int OFS_QUERY  = 74;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] CFG_ENTRY_COUNT = 3'd0;
    localparam logic [2:0] CFG_HOURLY      = 3'd1;
    localparam logic [2:0] CFG_AXIS        = 3'd2;
    localparam logic [2:0] CFG_WARMUP      = 3'd3;
    localparam logic [2:0] CFG_DEFAULT     = 3'd4;

    typedef enum logic [16:0] {
        ST_IDLE     = 17'h00001,
        ST_AX0      = 17'h00002,
        ST_AX1      = 17'h00004,
        ST_AXL      = 17'h00008,
        ST_DIV      = 17'h00010,
        ST_WRAP     = 17'h00020,
        ST_BS_ADDR  = 17'h00040,
        ST_BS_CMP   = 17'h00080,
        ST_IDX      = 17'h00100,
        ST_FETCH_LO = 17'h00200,
        ST_FETCH_HI = 17'h00400,
        ST_LERP_SET = 17'h00800,
        ST_MD       = 17'h01000,
        ST_MD_END   = 17'h02000,
        ST_RD_RES   = 17'h04000,
        ST_DONE     = 17'h08000,
        ST_UDIV     = 17'h10000
    } t_state;

endpackage

FILE: rtl/periodic_table_interpolator.sv
// Channel   Dir  Handshake                       Word
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: index, time, value, query; tuser: op
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: value; tuser: used_default
// cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// A query with a time axis runs a 32-step restoring divider for the wrap, a binary
// search over the table memory (one read port), an address state and a compare state
// per step, and a 33-step multiply-divide for the lerp. Without a time axis a query
// has no search: a divider pass for the wrap when hourly or when the shifted time is
// negative, then a reciprocal step (estimate, remainder, correction) for the sample index.
// Reset (synchronous, active low) clears control and configuration; the table is not
// cleared. A finished result is held until the output register is free, and the input
// stays stalled meanwhile; words are taken whenever the core is idle.
module periodic_table_interpolator
    import pti_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_index[9:0], entry_time[41:10], entry_value[73:42], query_time[105:74], zeros
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // op
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // value[31:0]
    output logic [31:0]           m_axis_tdata,
    // used_default
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    t_state r_state, r_ret;

    logic [NW-1:0]      r_cfg_count;
    logic               r_hourly;
    logic               r_axis;
    logic [30:0]        r_warmup;
    logic signed [31:0] r_default;

    logic signed [32:0] r_s;
    logic [31:0]        r_s_mag;
    logic [NW-1:0]      r_n;
    logic signed [31:0] r_t0, r_tl, r_v0, r_vl;
    logic [UW-1:0]      r_sp, r_span;
    logic signed [XW-1:0] r_target;
    logic [AW-1:0]      r_lo, r_hi;
    logic signed [31:0] r_tlo, r_thi, r_vlo, r_vhi;
    logic signed [XW-1:0] r_num, r_den;
    logic [UW-1:0]      r_md_a, r_md_r;
    logic [QW-1:0]      r_md_q, r_dmag;
    logic               r_dneg;
    logic [5:0]         r_cnt;
    logic [31:0]        r_dv_n, r_dv_q;
    logic [UW-1:0]      r_dv_r, r_dv_d;
    logic signed [31:0] r_res;
    logic               r_used;
    logic               r_mvalid;
    logic [31:0]        r_mdata;
    logic               r_muser;

    logic [31:0] mem_t [DEPTH];
    logic [31:0] mem_v [DEPTH];
    logic signed [31:0] rd_t, rd_v;
    logic [AW-1:0] rd_addr;

    logic               s_acc, wr_en;
    logic [9:0]         in_index;
    logic signed [31:0] in_time, in_value, in_query;
    logic signed [32:0] s_in, s_neg_val;
    logic [31:0]        s_mag;
    logic [NW-1:0]      n_sat;
    logic [UW-1:0]      unit, span_hour, span_day;
    logic signed [32:0] d01;
    logic [QW-1:0]      sp_abs;
    logic [UW-1:0]      sp_eff, span_ax;
    logic signed [XW-1:0] span_raw, sp_eff_s;
    logic [UW-1:0]      w;
    logic signed [XW-1:0] target, tl_x, wrap_num, wrap_den;
    logic [AW-1:0]      bs_mid;
    logic               bs_more;
    logic               idx_clamp, idx_wrap;
    logic [AW-1:0]      idx_lo, idx_hi;
    logic [UW-1:0]      num_c;
    logic signed [32:0] lerp_d;
    logic [QW-1:0]      lerp_mag;
    logic [UW-1:0]      md_r1, md_r2, md_r3, md_rn, den_u;
    logic               md_ge1, md_ge2;
    logic [QW-1:0]      md_qn;
    logic [UW-1:0]      dv_p, dv_rn;
    logic               dv_ge;
    logic [31:0]        ud_recip;
    logic [63:0]        ud_prod;
    logic [UW-1:0]      ud_rem;

    assign s_acc          = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign m_axis_tvalid  = r_mvalid;
    assign m_axis_tdata   = r_mdata;
    assign m_axis_tuser   = r_muser;

    assign in_index = s_axis_tdata[OFS_INDEX +: 10];
    assign in_time  = s_axis_tdata[OFS_TIME +: 32];
    assign in_value = s_axis_tdata[OFS_VALUE +: 32];
    assign in_query = s_axis_tdata[OFS_QUERY +: 32];
    assign wr_en    = s_acc && (s_axis_tuser == OP_LOAD) && (int'(in_index) < DEPTH);

    always_comb begin
        s_in      = $signed({in_query[31], in_query}) - $signed({2'b00, r_warmup});
        s_neg_val = -s_in;
        s_mag     = s_in[32] ? s_neg_val[31:0] : s_in[31:0];
        n_sat     = (int'(r_cfg_count) > DEPTH) ? NW'(DEPTH) : r_cfg_count;
        unit      = r_hourly ? UW'(UNIT_HOUR) : UW'(UNIT_DAY);
        span_hour = UW'(n_sat - 1'b1) * UW'(UNIT_HOUR);
        span_day  = UW'(n_sat) * UW'(UNIT_DAY);

        d01    = $signed({rd_t[31], rd_t}) - $signed({r_t0[31], r_t0});
        sp_abs = d01[32] ? QW'(-d01) : QW'(d01);

        sp_eff   = (r_sp == '0) ? unit : r_sp;
        sp_eff_s = $signed({1'b0, sp_eff});
        span_raw = XW'(rd_t) - XW'(r_t0) + sp_eff_s;
        span_ax  = (span_raw < sp_eff_s) ? sp_eff : span_raw[UW-1:0];

        // fold the remainder of |s| back onto the positive side
        w        = (r_s[32] && r_dv_r != '0) ? r_span - r_dv_r : r_dv_r;
        tl_x     = XW'(r_tl);
        target   = XW'(r_t0) + $signed({1'b0, w});
        wrap_num = target - tl_x;
        wrap_den = XW'(r_t0) + $signed({1'b0, r_span}) - tl_x;

        bs_mid  = AW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
        bs_more = (r_hi - r_lo) > AW'(1);

        idx_clamp = !r_hourly && !r_s[32] && (r_dv_q >= 32'(r_n) - 32'd1);
        idx_wrap  = !r_hourly && r_s[32] && (r_dv_q + 32'd1 == 32'(r_n));
        idx_lo    = AW'(r_dv_q);
        idx_hi    = idx_wrap ? '0 : AW'(r_dv_q + 32'd1);

        if (r_num < 0)
            num_c = '0;
        else if (r_num > r_den)
            num_c = r_den[UW-1:0];
        else
            num_c = r_num[UW-1:0];
        lerp_d   = $signed({r_vhi[31], r_vhi}) - $signed({r_vlo[31], r_vlo});
        lerp_mag = lerp_d[32] ? QW'(-lerp_d) : QW'(lerp_d);

        den_u  = r_den[UW-1:0];
        md_r1  = {r_md_r[UW-2:0], 1'b0};
        md_ge1 = md_r1 >= den_u;
        md_r2  = md_ge1 ? md_r1 - den_u : md_r1;
        md_r3  = md_r2 + (r_dmag[QW-1] ? r_md_a : '0);
        md_ge2 = md_r3 >= den_u;
        md_rn  = md_ge2 ? md_r3 - den_u : md_r3;
        md_qn  = {r_md_q[QW-2:0], 1'b0} + QW'(md_ge1) + QW'(md_ge2);

        dv_p  = {r_dv_r[UW-2:0], r_dv_n[31]};
        dv_ge = dv_p >= r_dv_d;
        dv_rn = dv_ge ? dv_p - r_dv_d : dv_p;

        // quotient estimate by the unit is low by at most one
        ud_recip = r_hourly ? RECIP_HOUR : RECIP_DAY;
        ud_prod  = 64'(r_dv_n) * 64'(ud_recip);
        ud_rem   = UW'(r_dv_n - r_dv_q * unit[31:0]);
    end

    // read address for the word that the next state takes from the memory
    always_comb begin
        case (r_state)
            ST_AX0:      rd_addr = AW'(1);
            ST_AX1:      rd_addr = AW'(r_n - 1'b1);
            ST_BS_ADDR:  rd_addr = bs_more ? bs_mid : r_lo;
            ST_IDX:      rd_addr = idx_clamp ? AW'(r_n - 1'b1) : idx_lo;
            ST_FETCH_LO: rd_addr = r_hi;
            default:     rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_t[AW'(in_index)] <= in_time;
            mem_v[AW'(in_index)] <= in_value;
        end
        rd_t <= mem_t[rd_addr];
        rd_v <= mem_v[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_IDLE;
            r_mvalid    <= 1'b0;
            r_cfg_count <= '0;
            r_hourly    <= 1'b0;
            r_axis      <= 1'b1;
            r_warmup    <= '0;
            r_default   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENTRY_COUNT: r_cfg_count <= i_cfg_data[NW-1:0];
                    CFG_HOURLY:      r_hourly    <= i_cfg_data[0];
                    CFG_AXIS:        r_axis      <= i_cfg_data[0];
                    CFG_WARMUP:      r_warmup    <= i_cfg_data[30:0];
                    CFG_DEFAULT:     r_default   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_mvalid && m_axis_tready && r_state != ST_DONE)
                r_mvalid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (s_acc && s_axis_tuser == OP_QUERY) begin
                        r_s     <= s_in;
                        r_s_mag <= s_mag;
                        r_n     <= n_sat;
                        r_used  <= (n_sat == '0);
                        r_dv_r  <= '0;
                        r_dv_q  <= '0;
                        if (n_sat == '0) begin
                            r_res   <= r_default;
                            r_state <= ST_DONE;
                        end else if (r_axis) begin
                            r_cnt   <= 6'(DIV_STEPS - 1);
                            r_state <= ST_AX0;
                        end else if (n_sat == NW'(1)) begin
                            r_state <= ST_RD_RES;
                        end else if (r_hourly || s_in[32]) begin
                            r_span  <= r_hourly ? span_hour : span_day;
                            r_dv_n  <= s_mag;
                            r_dv_d  <= r_hourly ? span_hour : span_day;
                            r_cnt   <= 6'(DIV_STEPS - 1);
                            r_ret   <= ST_WRAP;
                            r_state <= ST_DIV;
                        end else begin
                            r_dv_n  <= s_in[31:0];
                            r_cnt   <= 6'(UD_STEPS - 1);
                            r_state <= ST_UDIV;
                        end
                    end
                end
                ST_AX0: begin
                    r_t0    <= rd_t;
                    r_v0    <= rd_v;
                    r_state <= ST_AX1;
                end
                ST_AX1: begin
                    r_sp    <= (r_n > NW'(1)) ? UW'(sp_abs) : '0;
                    r_state <= ST_AXL;
                end
                ST_AXL: begin
                    r_tl    <= rd_t;
                    r_vl    <= rd_v;
                    r_span  <= span_ax;
                    r_dv_n  <= r_s_mag;
                    r_dv_d  <= span_ax;
                    r_ret   <= ST_WRAP;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_dv_r <= dv_rn;
                    r_dv_q <= {r_dv_q[30:0], dv_ge};
                    r_dv_n <= {r_dv_n[30:0], 1'b0};
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == '0)
                        r_state <= r_ret;
                end
                ST_UDIV: begin
                    // estimate, then remainder, then one correction step
                    case (r_cnt)
                        6'd2: r_dv_q <= ud_prod[63:32];
                        6'd1: r_dv_r <= ud_rem;
                        default: begin
                            if (r_dv_r >= unit) begin
                                r_dv_r <= r_dv_r - unit;
                                r_dv_q <= r_dv_q + 32'd1;
                            end
                            r_state <= ST_IDX;
                        end
                    endcase
                    r_cnt <= r_cnt - 6'd1;
                end
                ST_WRAP: begin
                    if (r_axis) begin
                        if (w == '0) begin
                            r_res   <= r_v0;
                            r_state <= ST_DONE;
                        end else if (target >= tl_x) begin
                            // between the last entry and the first of the next period
                            r_vlo   <= r_vl;
                            r_vhi   <= r_v0;
                            r_num   <= wrap_num;
                            r_den   <= wrap_den;
                            r_state <= ST_LERP_SET;
                        end else begin
                            r_target <= target;
                            r_lo     <= '0;
                            r_hi     <= AW'(r_n - 1'b1);
                            r_tlo    <= r_t0;
                            r_thi    <= r_tl;
                            r_state  <= ST_BS_ADDR;
                        end
                    end else begin
                        r_dv_n  <= w[31:0];
                        r_cnt   <= 6'(UD_STEPS - 1);
                        r_state <= ST_UDIV;
                    end
                end
                ST_BS_ADDR: begin
                    if (bs_more) begin
                        r_state <= ST_BS_CMP;
                    end else begin
                        r_num   <= r_target - XW'(r_tlo);
                        r_den   <= XW'(r_thi) - XW'(r_tlo);
                        r_state <= ST_FETCH_LO;
                    end
                end
                ST_BS_CMP: begin
                    if (XW'(rd_t) <= r_target) begin
                        r_lo  <= bs_mid;
                        r_tlo <= rd_t;
                    end else begin
                        r_hi  <= bs_mid;
                        r_thi <= rd_t;
                    end
                    r_state <= ST_BS_ADDR;
                end
                ST_IDX: begin
                    if (idx_clamp) begin
                        r_state <= ST_RD_RES;
                    end else begin
                        r_lo    <= idx_lo;
                        r_hi    <= idx_hi;
                        r_num   <= $signed({1'b0, r_dv_r});
                        r_den   <= $signed({1'b0, unit});
                        r_state <= ST_FETCH_LO;
                    end
                end
                ST_FETCH_LO: begin
                    r_vlo   <= rd_v;
                    r_state <= ST_FETCH_HI;
                end
                ST_FETCH_HI: begin
                    r_vhi   <= rd_v;
                    r_state <= ST_LERP_SET;
                end
                ST_LERP_SET: begin
                    if (r_den <= 0) begin
                        r_res   <= r_vlo;
                        r_state <= ST_DONE;
                    end else begin
                        r_md_a  <= num_c;
                        r_md_r  <= '0;
                        r_md_q  <= '0;
                        r_dmag  <= lerp_mag;
                        r_dneg  <= lerp_d[32];
                        r_cnt   <= 6'(MD_STEPS - 1);
                        r_state <= ST_MD;
                    end
                end
                ST_MD: begin
                    r_md_r <= md_rn;
                    r_md_q <= md_qn;
                    r_dmag <= {r_dmag[QW-2:0], 1'b0};
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == '0)
                        r_state <= ST_MD_END;
                end
                ST_MD_END: begin
                    r_res   <= r_dneg ? r_vlo - $signed(r_md_q[31:0])
                                      : r_vlo + $signed(r_md_q[31:0]);
                    r_state <= ST_DONE;
                end
                ST_RD_RES: begin
                    r_res   <= rd_v;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!r_mvalid || m_axis_tready) begin
                        r_mvalid <= 1'b1;
                        r_mdata  <= r_res;
                        r_muser  <= r_used;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_dv_r < r_dv_d)
        else $error("divider remainder not below divisor");

    a_md_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MD |-> r_md_r < r_den[UW-1:0])
        else $error("lerp remainder not below denominator");

    a_bs_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_BS_ADDR |-> r_lo < r_hi)
        else $error("search bracket collapsed");

    a_div_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV && r_cnt == '0 |=> r_state == $past(r_ret))
        else $error("divider did not return to caller");

    a_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == r_default)
        else $error("default word does not match register");

endmodule
